// ----- hw/rtl/bmf_pkg.sv -----
// bmf_pkg: shared constants, register codes and types of the box mean filter
// used by every module of the block; depends on nothing
`default_nettype none

package bmf_pkg;

  localparam int MAX_WIDTH     = 1024;
  localparam int MAX_WINDOW    = 15;
  localparam int MAX_HEIGHT    = 4096;
  localparam int NUM_CH        = 3;
  localparam int ROW_BYTES_MAX = NUM_CH * MAX_WIDTH;
  localparam int ROW_DEPTH     = MAX_WINDOW * ROW_BYTES_MAX;

  localparam int PIX_W   = 8;
  localparam int W_W     = 11;
  localparam int H_W     = 13;
  localparam int WIN_W   = 4;
  localparam int B_W     = $clog2(ROW_BYTES_MAX);
  localparam int X_W     = $clog2(MAX_WIDTH);
  localparam int C_W     = $clog2(NUM_CH);
  localparam int SLOT_W  = $clog2(MAX_WINDOW);
  localparam int ROW_AW  = $clog2(ROW_DEPTH);
  localparam int IDX_W   = $clog2(ROW_BYTES_MAX * MAX_HEIGHT + 1);
  localparam int CS_W    = $clog2(MAX_WINDOW * 255 + 1);
  localparam int WS_W    = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
  localparam int DV_W    = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int WWCH_W  = $clog2(MAX_WINDOW * NUM_CH + 1);
  localparam int APB_AW  = 5;
  localparam int APB_DW  = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COLOR_MODE    = 3'd4;

  localparam int RST_IMAGE_WIDTH   = 640;
  localparam int RST_IMAGE_HEIGHT  = 480;
  localparam int RST_WINDOW_WIDTH  = 3;
  localparam int RST_WINDOW_HEIGHT = 3;
  localparam int RST_TOTAL = RST_IMAGE_WIDTH * RST_IMAGE_HEIGHT;
  localparam int RST_DELAY = (RST_WINDOW_HEIGHT / 2) * RST_IMAGE_WIDTH
                             + (RST_WINDOW_WIDTH / 2);

  typedef struct packed {
    logic [W_W-1:0]   image_width;
    logic [H_W-1:0]   image_height;
    logic [WIN_W-1:0] window_width;
    logic [WIN_W-1:0] window_height;
    logic             color_mode;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic start;
    logic geo1;
    logic geo2;
    logic rd;
    logic upd;
    logic frd;
    logic div_go;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic frame_idle;
    logic flush_ok;
    logic emit;
    logic filt;
    logic div_busy;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [B_W-1:0]    b;
    logic [X_W-1:0]    x;
    logic [C_W-1:0]    c;
    logic [H_W-1:0]    row;
    logic [SLOT_W-1:0] slot;
  } pos_t;

  // clamp to the window range, then force an odd size
  function automatic logic [WIN_W-1:0] fix_window(input logic [WIN_W-1:0] v);
    logic [WIN_W-1:0] e;
    e = (32'(v) > MAX_WINDOW) ? WIN_W'(MAX_WINDOW) : v;
    if (e == '0) e = WIN_W'(1);
    if (!e[0]) e = e - WIN_W'(1);
    return e;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bmf_regs.sv -----
// bmf_regs: APB-style configuration registers of the box mean filter
// depends on bmf_pkg
`default_nettype none

module bmf_regs (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [bmf_pkg::APB_AW-1:0] paddr,
  input  wire logic [bmf_pkg::APB_DW-1:0] pwdata,
  output logic      [bmf_pkg::APB_DW-1:0] prdata,
  output logic                           pready,
  output bmf_pkg::cfg_t                  cfg
);

  logic [bmf_pkg::W_W-1:0]   iw_r;
  logic [bmf_pkg::H_W-1:0]   ih_r;
  logic [bmf_pkg::WIN_W-1:0] ww_r;
  logic [bmf_pkg::WIN_W-1:0] wh_r;
  logic                      cm_r;
  logic                      wr;
  logic [bmf_pkg::REG_IDX_W-1:0] idx;

  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[bmf_pkg::APB_AW-1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iw_r <= bmf_pkg::W_W'(bmf_pkg::RST_IMAGE_WIDTH);
      ih_r <= bmf_pkg::H_W'(bmf_pkg::RST_IMAGE_HEIGHT);
      ww_r <= bmf_pkg::WIN_W'(bmf_pkg::RST_WINDOW_WIDTH);
      wh_r <= bmf_pkg::WIN_W'(bmf_pkg::RST_WINDOW_HEIGHT);
      cm_r <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        bmf_pkg::REG_IMAGE_WIDTH:   iw_r <= pwdata[bmf_pkg::W_W-1:0];
        bmf_pkg::REG_IMAGE_HEIGHT:  ih_r <= pwdata[bmf_pkg::H_W-1:0];
        bmf_pkg::REG_WINDOW_WIDTH:  ww_r <= pwdata[bmf_pkg::WIN_W-1:0];
        bmf_pkg::REG_WINDOW_HEIGHT: wh_r <= pwdata[bmf_pkg::WIN_W-1:0];
        bmf_pkg::REG_COLOR_MODE:    cm_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bmf_pkg::REG_IMAGE_WIDTH:   prdata = bmf_pkg::APB_DW'(iw_r);
      bmf_pkg::REG_IMAGE_HEIGHT:  prdata = bmf_pkg::APB_DW'(ih_r);
      bmf_pkg::REG_WINDOW_WIDTH:  prdata = bmf_pkg::APB_DW'(ww_r);
      bmf_pkg::REG_WINDOW_HEIGHT: prdata = bmf_pkg::APB_DW'(wh_r);
      bmf_pkg::REG_COLOR_MODE:    prdata = bmf_pkg::APB_DW'(cm_r);
      default:                    prdata = '0;
    endcase
  end

  assign cfg.image_width   = iw_r;
  assign cfg.image_height  = ih_r;
  assign cfg.window_width  = ww_r;
  assign cfg.window_height = wh_r;
  assign cfg.color_mode    = cm_r;

endmodule

`default_nettype wire

// ----- hw/rtl/bmf_div.sv -----
// bmf_div: restoring divider, one quotient bit per cycle, for the window mean
// depends on bmf_pkg
`default_nettype none

module bmf_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [bmf_pkg::WS_W-1:0] dividend,
  input  wire logic [bmf_pkg::DV_W-1:0] divisor,
  output logic                          busy,
  output logic [bmf_pkg::PIX_W-1:0]     quotient
);

  localparam int CNT_W = $clog2(bmf_pkg::WS_W + 1);

  logic [CNT_W-1:0]            cnt_r;
  logic [bmf_pkg::WS_W-1:0]    q_r;
  logic [bmf_pkg::DV_W:0]      rem_r;
  logic [bmf_pkg::DV_W-1:0]    dvs_r;
  logic [bmf_pkg::DV_W:0]      rem_sh;
  logic                        ge;

  assign rem_sh = {rem_r[bmf_pkg::DV_W-1:0], q_r[bmf_pkg::WS_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(bmf_pkg::WS_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      q_r   <= {q_r[bmf_pkg::WS_W-2:0], ge};
    end
  end

  assign busy     = cnt_r != '0;
  // the mean of byte samples never exceeds one byte
  assign quotient = q_r[bmf_pkg::PIX_W-1:0];

endmodule

`default_nettype wire

// ----- hw/rtl/bmf_ctrl.sv -----
// bmf_ctrl: sequencing state machine of the box mean filter
// depends on bmf_pkg; drives bmf_dpath through cmd_t, reads status_t
`default_nettype none

module bmf_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_is_flush,
  input  wire logic             in_frame_start,
  output logic                  in_ready,
  input  wire bmf_pkg::status_t status,
  output bmf_pkg::cmd_t         cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_GEO1 = 4'd1;
  localparam logic [3:0] S_GEO2 = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_UPD  = 4'd4;
  localparam logic [3:0] S_FRD  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_PUSH = 4'd7;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_is_flush) begin
            if (status.flush_ok) state_nxt = S_FRD;
          end else if (in_frame_start || status.frame_idle) begin
            cmd.start = 1'b1;
            state_nxt = S_GEO1;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_GEO1: begin
        cmd.geo1  = 1'b1;
        state_nxt = S_GEO2;
      end
      S_GEO2: begin
        cmd.geo2  = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        if (status.emit) begin
          if (status.filt) begin
            cmd.div_go = 1'b1;
            state_nxt  = S_DIV;
          end else begin
            state_nxt = S_PUSH;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FRD: begin
        cmd.frd = 1'b1;
        if (status.filt) begin
          cmd.div_go = 1'b1;
          state_nxt  = S_DIV;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_DIV: begin
        if (!status.div_busy) state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (status.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bmf_dpath.sv -----
// bmf_dpath: geometry, counters, row and column-sum memories, running sums,
// divider and output register of the box mean filter; depends on bmf_pkg, bmf_div
`default_nettype none

module bmf_dpath (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire bmf_pkg::cfg_t             cfg,
  input  wire bmf_pkg::cmd_t             cmd,
  output bmf_pkg::status_t               status,
  input  wire logic [bmf_pkg::PIX_W-1:0] in_sample_in,
  input  wire logic                      out_ready,
  output logic                           out_valid,
  output logic      [bmf_pkg::PIX_W-1:0] out_sample_out,
  output logic                           out_was_filtered,
  output logic                           out_frame_last
);

  // frame geometry, latched at frame start
  logic [bmf_pkg::W_W-1:0]    g_w_r;
  logic [bmf_pkg::H_W-1:0]    g_h_r;
  logic [bmf_pkg::WIN_W-1:0]  g_ww_r;
  logic [bmf_pkg::WIN_W-1:0]  g_wh_r;
  logic                       rgb_r;
  logic [bmf_pkg::B_W-1:0]    rb_r;
  logic [bmf_pkg::WWCH_W-1:0] wwch_r;
  logic [bmf_pkg::DV_W-1:0]   dv_r;
  logic                       small_r;
  logic [bmf_pkg::IDX_W-1:0]  total_r;
  logic [bmf_pkg::IDX_W-1:0]  delay_r;

  bmf_pkg::pos_t              in_p_r;
  bmf_pkg::pos_t              out_p_r;
  logic [bmf_pkg::IDX_W-1:0]  in_lin_r;
  logic [bmf_pkg::IDX_W-1:0]  out_idx_r;
  logic                       frame_idle_r;
  logic [bmf_pkg::WS_W-1:0]   ws_r [bmf_pkg::NUM_CH];

  logic [bmf_pkg::PIX_W-1:0]  sample_r;
  logic [bmf_pkg::PIX_W-1:0]  row_mem [bmf_pkg::ROW_DEPTH];
  logic [bmf_pkg::CS_W-1:0]   col_mem [bmf_pkg::ROW_BYTES_MAX];
  logic [bmf_pkg::PIX_W-1:0]  old_q;
  logic [bmf_pkg::PIX_W-1:0]  pass_q;
  logic [bmf_pkg::CS_W-1:0]   col_q;
  logic [bmf_pkg::CS_W-1:0]   far_q;

  logic                       out_valid_r;
  logic [bmf_pkg::PIX_W-1:0]  out_sample_r;
  logic                       out_filt_r;
  logic                       out_last_r;

  logic [bmf_pkg::WIN_W-1:0]  hww;
  logic [bmf_pkg::WIN_W-1:0]  hwh;
  logic [bmf_pkg::SLOT_W:0]   slot_wrap;
  logic [bmf_pkg::SLOT_W-1:0] old_slot;
  logic [bmf_pkg::ROW_AW-1:0] in_addr;
  logic [bmf_pkg::ROW_AW-1:0] old_addr;
  logic [bmf_pkg::ROW_AW-1:0] out_addr;
  logic [bmf_pkg::B_W-1:0]    far_b;
  logic                       need_old;
  logic                       far_ok;
  logic [bmf_pkg::CS_W-1:0]   col_new;
  logic [bmf_pkg::WS_W-1:0]   ws_base;
  logic [bmf_pkg::WS_W-1:0]   ws_new;
  logic                       in_end;
  logic                       emit;
  logic                       filt;
  logic                       out_has;
  logic [bmf_pkg::WS_W-1:0]   div_in;
  logic                       div_busy;
  logic [bmf_pkg::PIX_W-1:0]  quot;

  function automatic logic [bmf_pkg::ROW_AW-1:0] row_addr(
    input logic [bmf_pkg::SLOT_W-1:0] slot,
    input logic [bmf_pkg::B_W-1:0]    b
  );
    return bmf_pkg::ROW_AW'(slot) * bmf_pkg::ROW_AW'(bmf_pkg::ROW_BYTES_MAX)
           + bmf_pkg::ROW_AW'(b);
  endfunction

  function automatic logic row_last(
    input bmf_pkg::pos_t          p,
    input logic [bmf_pkg::B_W-1:0] rb
  );
    return bmf_pkg::B_W'(p.b + 1'b1) == rb;
  endfunction

  // raster position after one byte
  function automatic bmf_pkg::pos_t pos_next(
    input bmf_pkg::pos_t           p,
    input logic                    rgb,
    input logic [bmf_pkg::B_W-1:0] rb
  );
    bmf_pkg::pos_t n;
    n = p;
    if (row_last(p, rb)) begin
      n.b   = '0;
      n.x   = '0;
      n.c   = '0;
      n.row = p.row + 1'b1;
      n.slot = (p.slot == bmf_pkg::SLOT_W'(bmf_pkg::MAX_WINDOW - 1)) ? '0
               : p.slot + 1'b1;
    end else begin
      n.b = p.b + 1'b1;
      if (rgb && p.c != bmf_pkg::C_W'(bmf_pkg::NUM_CH - 1)) begin
        n.c = p.c + 1'b1;
      end else begin
        n.c = '0;
        n.x = p.x + 1'b1;
      end
    end
    return n;
  endfunction

  assign hww = g_ww_r >> 1;
  assign hwh = g_wh_r >> 1;

  // slot of the row leaving the window, modulo the row store depth
  assign slot_wrap = {1'b0, in_p_r.slot} + (bmf_pkg::SLOT_W + 1)'(bmf_pkg::MAX_WINDOW)
                     - {1'b0, bmf_pkg::SLOT_W'(g_wh_r)};
  assign old_slot  = (in_p_r.slot >= bmf_pkg::SLOT_W'(g_wh_r))
                     ? in_p_r.slot - bmf_pkg::SLOT_W'(g_wh_r)
                     : slot_wrap[bmf_pkg::SLOT_W-1:0];

  assign in_addr  = row_addr(in_p_r.slot, in_p_r.b);
  assign old_addr = row_addr(old_slot, in_p_r.b);
  assign out_addr = row_addr(out_p_r.slot, out_p_r.b);
  assign far_b    = in_p_r.b - bmf_pkg::B_W'(wwch_r);

  assign need_old = in_p_r.row >= bmf_pkg::H_W'(g_wh_r);
  assign far_ok   = bmf_pkg::W_W'(in_p_r.x) >= bmf_pkg::W_W'(g_ww_r);

  // first row of a frame sees cleared column sums
  assign col_new = ((in_p_r.row == '0) ? '0 : col_q) + bmf_pkg::CS_W'(sample_r)
                   - (need_old ? bmf_pkg::CS_W'(old_q) : '0);
  assign ws_base = (in_p_r.x == '0) ? '0 : ws_r[in_p_r.c];
  assign ws_new  = ws_base + bmf_pkg::WS_W'(col_new)
                   - (far_ok ? bmf_pkg::WS_W'(far_q) : '0);

  assign in_end  = row_last(in_p_r, rb_r);
  assign emit    = ({1'b0, out_idx_r} + {1'b0, delay_r} <= {1'b0, in_lin_r})
                   && (out_idx_r < total_r);
  assign out_has = out_idx_r < total_r;
  assign filt    = !small_r
                   && out_p_r.row >= bmf_pkg::H_W'(hwh)
                   && out_p_r.row <  g_h_r - bmf_pkg::H_W'(hwh)
                   && bmf_pkg::W_W'(out_p_r.x) >= bmf_pkg::W_W'(hww)
                   && bmf_pkg::W_W'(out_p_r.x) <  g_w_r - bmf_pkg::W_W'(hww);

  assign div_in = cmd.upd ? ws_new : ws_r[out_p_r.c];

  bmf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .dividend (div_in),
    .divisor  (dv_r),
    .busy     (div_busy),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_w_r   <= bmf_pkg::W_W'(bmf_pkg::RST_IMAGE_WIDTH);
      g_h_r   <= bmf_pkg::H_W'(bmf_pkg::RST_IMAGE_HEIGHT);
      g_ww_r  <= bmf_pkg::WIN_W'(bmf_pkg::RST_WINDOW_WIDTH);
      g_wh_r  <= bmf_pkg::WIN_W'(bmf_pkg::RST_WINDOW_HEIGHT);
      rgb_r   <= 1'b0;
      rb_r    <= bmf_pkg::B_W'(bmf_pkg::RST_IMAGE_WIDTH);
      wwch_r  <= bmf_pkg::WWCH_W'(bmf_pkg::RST_WINDOW_WIDTH);
      dv_r    <= bmf_pkg::DV_W'(bmf_pkg::RST_WINDOW_WIDTH * bmf_pkg::RST_WINDOW_HEIGHT);
      small_r <= 1'b0;
      total_r <= bmf_pkg::IDX_W'(bmf_pkg::RST_TOTAL);
      delay_r <= bmf_pkg::IDX_W'(bmf_pkg::RST_DELAY);
    end else if (cmd.start) begin
      g_w_r  <= (cfg.image_width == '0) ? bmf_pkg::W_W'(1)
                : (32'(cfg.image_width) > bmf_pkg::MAX_WIDTH)
                  ? bmf_pkg::W_W'(bmf_pkg::MAX_WIDTH) : cfg.image_width;
      g_h_r  <= (cfg.image_height == '0) ? bmf_pkg::H_W'(1)
                : (32'(cfg.image_height) > bmf_pkg::MAX_HEIGHT)
                  ? bmf_pkg::H_W'(bmf_pkg::MAX_HEIGHT) : cfg.image_height;
      g_ww_r <= bmf_pkg::fix_window(cfg.window_width);
      g_wh_r <= bmf_pkg::fix_window(cfg.window_height);
      rgb_r  <= cfg.color_mode;
    end else if (cmd.geo1) begin
      rb_r    <= rgb_r ? bmf_pkg::B_W'(g_w_r) + bmf_pkg::B_W'({g_w_r, 1'b0})
                       : bmf_pkg::B_W'(g_w_r);
      wwch_r  <= rgb_r ? bmf_pkg::WWCH_W'(g_ww_r) + bmf_pkg::WWCH_W'({g_ww_r, 1'b0})
                       : bmf_pkg::WWCH_W'(g_ww_r);
      dv_r    <= bmf_pkg::DV_W'(g_ww_r) * bmf_pkg::DV_W'(g_wh_r);
      small_r <= (g_w_r < bmf_pkg::W_W'(g_ww_r)) || (g_h_r < bmf_pkg::H_W'(g_wh_r));
    end else if (cmd.geo2) begin
      total_r <= bmf_pkg::IDX_W'(rb_r) * bmf_pkg::IDX_W'(g_h_r);
      delay_r <= bmf_pkg::IDX_W'(hwh) * bmf_pkg::IDX_W'(rb_r)
                 + (rgb_r ? bmf_pkg::IDX_W'(hww) * bmf_pkg::IDX_W'(bmf_pkg::NUM_CH)
                          : bmf_pkg::IDX_W'(hww));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_p_r       <= '0;
      out_p_r      <= '0;
      in_lin_r     <= '0;
      out_idx_r    <= '0;
      frame_idle_r <= 1'b1;
      for (int i = 0; i < bmf_pkg::NUM_CH; i++) ws_r[i] <= '0;
    end else if (cmd.start) begin
      in_p_r       <= '0;
      out_p_r      <= '0;
      in_lin_r     <= '0;
      out_idx_r    <= '0;
      frame_idle_r <= 1'b0;
      for (int i = 0; i < bmf_pkg::NUM_CH; i++) ws_r[i] <= '0;
    end else begin
      if (cmd.upd) begin
        in_p_r            <= pos_next(in_p_r, rgb_r, rb_r);
        in_lin_r          <= in_lin_r + 1'b1;
        ws_r[in_p_r.c]    <= ws_new;
        if (in_end && (bmf_pkg::H_W'(in_p_r.row + 1'b1) == g_h_r)) frame_idle_r <= 1'b1;
      end
      if (cmd.push) begin
        out_p_r   <= pos_next(out_p_r, rgb_r, rb_r);
        out_idx_r <= out_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) sample_r <= in_sample_in;
    if (cmd.upd)  row_mem[in_addr] <= sample_r;
    if (cmd.rd)   old_q <= row_mem[old_addr];
    if (cmd.rd || cmd.frd) pass_q <= row_mem[out_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) col_mem[in_p_r.b] <= col_new;
    if (cmd.rd) begin
      col_q <= col_mem[in_p_r.b];
      far_q <= col_mem[far_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)         out_valid_r <= 1'b0;
    else if (cmd.push)  out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_sample_r <= filt ? quot : pass_q;
      out_filt_r   <= filt;
      out_last_r   <= bmf_pkg::IDX_W'(out_idx_r + 1'b1) == total_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_out   = out_sample_r;
  assign out_was_filtered = out_filt_r;
  assign out_frame_last   = out_last_r;

  assign status.frame_idle = frame_idle_r;
  assign status.flush_ok   = frame_idle_r && out_has;
  assign status.emit       = emit;
  assign status.filt       = filt;
  assign status.div_busy   = div_busy;
  assign status.out_free   = !out_valid_r || out_ready;

endmodule

`default_nettype wire

// ----- hw/rtl/box_mean_filter.sv -----
// box_mean_filter: streaming W x H mean filter, gray or interleaved RGB bytes
// a sample passes IDLE (load), RD, UPD and, with a result, PUSH; a window mean adds DIV
// (16-step shift-subtract divider); a frame start adds the geometry states GEO1, GEO2
// throughput: one item at a time through the controller; a flush emits one pending result
// results leave in raster order; each starts once (H/2)*row_bytes+(W/2)*channels more bytes are in
// reset (synchronous, rst_n low): registers to defaults, idle, output empty
`default_nettype none

module box_mean_filter (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [bmf_pkg::PIX_W-1:0] in_sample_in,
  input  wire logic                      in_is_flush,
  input  wire logic                      in_frame_start,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic      [bmf_pkg::PIX_W-1:0] out_sample_out,
  output logic                           out_was_filtered,
  output logic                           out_frame_last,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [bmf_pkg::APB_AW-1:0] paddr,
  input  wire logic [bmf_pkg::APB_DW-1:0] pwdata,
  output logic      [bmf_pkg::APB_DW-1:0] prdata,
  output logic                           pready
);

  bmf_pkg::cfg_t    cfg;
  bmf_pkg::cmd_t    cmd;
  bmf_pkg::status_t status;

  bmf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bmf_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_is_flush    (in_is_flush),
    .in_frame_start (in_frame_start),
    .in_ready       (in_ready),
    .status         (status),
    .cmd            (cmd)
  );

  bmf_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .status           (status),
    .in_sample_in     (in_sample_in),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_sample_out   (out_sample_out),
    .out_was_filtered (out_was_filtered),
    .out_frame_last   (out_frame_last)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/bmf_checker.sv -----
// bmf_checker: port-level checks of the box mean filter, bound to the top level
// depends on bmf_pkg and box_mean_filter
`default_nettype none

module bmf_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      in_is_flush,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [bmf_pkg::PIX_W-1:0] out_sample_out,
  input wire logic                      out_was_filtered,
  input wire logic                      out_frame_last,
  input wire logic                      pready
);

  // reset leaves the block ready with nothing to show
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("output or input side not clean after reset");

  // a sample always takes the sequencer away from the accept state
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_is_flush) |=> !in_ready)
    else $error("ready stayed high after a sample item");

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_sample_out)
      && $stable(out_was_filtered) && $stable(out_frame_last)))
    else $error("result changed or dropped while stalled");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("configuration port stalled");

endmodule

bind box_mean_filter bmf_checker u_bmf_checker (.*);

`default_nettype wire
